// File: src/assert_macros.svh
// Assertion helpers for the RTL, included by interp_next_change_time_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: src/inct_pkg.sv
package inct_pkg;

  // Time and value widths of the item fields.
  localparam int unsigned TIME_BITS = 40;
  localparam int unsigned NEXT_W    = TIME_BITS + 1;
  localparam int unsigned VAL_W     = 32;

  typedef struct packed {
    logic [TIME_BITS-1:0]    seg_start_time;
    logic [TIME_BITS-1:0]    now_time;
    logic [TIME_BITS-1:0]    seg_end_time;
    logic signed [VAL_W-1:0] start_value;
    logic signed [VAL_W-1:0] end_value;
    logic                    hold_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] current_value;
    logic [NEXT_W-1:0]       next_time;
    logic                    order_error;
  } out_item_t;

  // Status of a scaled quotient.
  typedef struct packed {
    logic ovf;   // quotient does not fit the quotient width
    logic neg;   // quotient is to be subtracted
  } scale_flags_t;

endpackage

// File: src/interp_next_change_time_unit.sv
// Interpolates a 32-bit value over a time segment and finds the next time the
// integer value changes. One item enters per clock and one result leaves per
// clock while the output is not stalled. The two pipelined dividers hold 33
// quotient stages for the value and 41 for the time, plus their multiply and
// setup stages. An input skid register takes one more item while a finished
// result waits on a stalled output.
`include "assert_macros.svh"

module interp_next_change_time_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  inct_pkg::in_item_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output inct_pkg::out_item_t    out_data_o
);

  localparam int unsigned T     = inct_pkg::TIME_BITS;
  localparam int unsigned N     = inct_pkg::NEXT_W;
  localparam int unsigned IN_W  = $bits(inct_pkg::in_item_t);
  localparam int unsigned S2_W  = IN_W + 32;

  logic adv;
  logic out_v_q;
  inct_pkg::out_item_t out_q, out_d;

  assign adv = !out_v_q || !out_stall_i;

  // Input skid
  logic skid_v_q;
  inct_pkg::in_item_t skid_q;
  logic acc;

  assign in_stall_o = skid_v_q;
  assign acc        = in_valid_i && !skid_v_q;

  logic s0_v_q;
  inct_pkg::in_item_t s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      s0_v_q   <= 1'b0;
    end else if (adv) begin
      skid_v_q <= 1'b0;
      s0_v_q   <= skid_v_q | in_valid_i;
    end else begin
      skid_v_q <= skid_v_q | acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && acc) skid_q <= in_data_i;
    if (adv) s0_q <= skid_v_q ? skid_q : in_data_i;
  end

  // Stage 0: magnitudes for the value division
  logic [T-1:0]        a1, d1;
  logic                na1, nd1, nb1;
  logic signed [32:0]  dx;
  logic [32:0]         b1;

  always_comb begin
    na1 = s0_q.now_time < s0_q.seg_start_time;
    a1  = na1 ? s0_q.seg_start_time - s0_q.now_time
              : s0_q.now_time - s0_q.seg_start_time;
    nd1 = s0_q.seg_end_time < s0_q.seg_start_time;
    d1  = nd1 ? s0_q.seg_start_time - s0_q.seg_end_time
              : s0_q.seg_end_time - s0_q.seg_start_time;
    dx  = 33'(s0_q.end_value) - 33'(s0_q.start_value);
    nb1 = dx < 0;
    b1  = nb1 ? 33'(-dx) : 33'(dx);
  end

  logic                    sc1_v;
  logic [32:0]             q1;
  inct_pkg::scale_flags_t  f1;
  logic [IN_W-1:0]         sc1_side;

  inct_scale #(
    .A_W(T), .B_W(33), .D_W(T), .Q_W(33), .SIDE_W(IN_W)
  ) u_scale_val (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s0_v_q),
    .a_i     (a1),
    .b_i     (b1),
    .d_i     (d1),
    .neg_i   (na1 ^ nb1 ^ nd1),
    .side_i  (s0_q),
    .valid_o (sc1_v),
    .quo_o   (q1),
    .flags_o (f1),
    .side_o  (sc1_side)
  );

  // Saturating add of the scaled value
  inct_pkg::in_item_t  it1;
  logic signed [34:0]  x1w, q1w, lim1, xsum;
  logic signed [31:0]  x_d;

  always_comb begin
    it1  = inct_pkg::in_item_t'(sc1_side);
    x1w  = 35'(it1.start_value);
    q1w  = signed'({2'b00, q1});
    if (!f1.neg) begin
      lim1 = 35'sd2147483647 - x1w;
      xsum = x1w + q1w;
      x_d  = (f1.ovf || q1w > lim1) ? 32'sh7fffffff : xsum[31:0];
    end else begin
      lim1 = x1w + 35'sd2147483648;
      xsum = x1w - q1w;
      x_d  = (f1.ovf || q1w > lim1) ? 32'sh80000000 : xsum[31:0];
    end
  end

  logic               s1_v_q;
  inct_pkg::in_item_t s1_q;
  logic signed [31:0] s1_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv) s1_v_q <= sc1_v;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= it1;
      s1_x_q <= x_d;
    end
  end

  // Stage 1: magnitudes for the time division
  logic signed [34:0] tgt, df2, dx2;
  logic               na2, nd2, nb2;
  logic [33:0]        a2;
  logic [T-1:0]       d2;
  logic [32:0]        b2;

  always_comb begin
    tgt = (s1_q.end_value < s1_q.start_value) ? 35'(s1_x_q) - 35'sd1
                                              : 35'(s1_x_q) + 35'sd1;
    df2 = tgt - 35'(s1_q.start_value);
    na2 = df2 < 0;
    a2  = na2 ? 34'(-df2) : 34'(df2);
    nd2 = s1_q.seg_end_time < s1_q.seg_start_time;
    d2  = nd2 ? s1_q.seg_start_time - s1_q.seg_end_time
              : s1_q.seg_end_time - s1_q.seg_start_time;
    dx2 = 35'(s1_q.end_value) - 35'(s1_q.start_value);
    nb2 = dx2 < 0;
    b2  = nb2 ? 33'(-dx2) : 33'(dx2);
  end

  logic                    sc2_v;
  logic [N-1:0]            q2;
  inct_pkg::scale_flags_t  f2;
  logic [S2_W-1:0]         sc2_side;

  inct_scale #(
    .A_W(T), .B_W(34), .D_W(33), .Q_W(N), .SIDE_W(S2_W)
  ) u_scale_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s1_v_q),
    .a_i     (d2),
    .b_i     (a2),
    .d_i     (b2),
    .neg_i   (na2 ^ nd2 ^ nb2),
    .side_i  ({s1_x_q, s1_q}),
    .valid_o (sc2_v),
    .quo_o   (q2),
    .flags_o (f2),
    .side_o  (sc2_side)
  );

  // Saturating add of the scaled time
  inct_pkg::in_item_t  it2;
  logic [N-1:0]        t1e, nxr_d;

  always_comb begin
    it2 = inct_pkg::in_item_t'(sc2_side[IN_W-1:0]);
    t1e = N'(it2.seg_start_time);
    if (!f2.neg) nxr_d = (f2.ovf || q2 > ({N{1'b1}} - t1e)) ? {N{1'b1}} : t1e + q2;
    else         nxr_d = (f2.ovf || q2 > t1e) ? '0 : t1e - q2;
  end

  logic               s2_v_q;
  inct_pkg::in_item_t s2_q;
  logic signed [31:0] s2_x_q;
  logic [N-1:0]       s2_nx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= sc2_v;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q    <= it2;
      s2_x_q  <= sc2_side[S2_W-1:IN_W];
      s2_nx_q <= nxr_d;
    end
  end

  // Stage 2: pick the case and fix up the next time
  logic [N-1:0] te, t2e, nx;
  logic         s2_err, s2_ramp;

  always_comb begin
    te      = N'(s2_q.now_time);
    t2e     = N'(s2_q.seg_end_time);
    s2_err  = !(s2_q.seg_start_time <= s2_q.now_time &&
                s2_q.now_time <= s2_q.seg_end_time);
    s2_ramp = 1'b0;
    out_d.current_value = s2_q.end_value;
    if (s2_q.now_time == s2_q.seg_end_time) begin
      nx = t2e + N'(1);
    end else if (s2_q.hold_mode) begin
      out_d.current_value = s2_q.start_value;
      nx = (t2e == '0) ? '0 : t2e - N'(1);
      if (nx == te) nx = t2e;
    end else if (s2_q.start_value == s2_q.end_value) begin
      nx = t2e;
    end else begin
      s2_ramp = 1'b1;
      out_d.current_value = s2_x_q;
      nx = (s2_nx_q <= te) ? te + N'(1) : s2_nx_q;
    end
    if (nx == te) nx = t2e;
    out_d.next_time   = nx;
    out_d.order_error = s2_err;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A ramp value inside a well-ordered segment lies between its endpoints.
  logic ramp_in_range;
  assign ramp_in_range =
    (s2_x_q >= s2_q.start_value && s2_x_q <= s2_q.end_value) ||
    (s2_x_q <= s2_q.start_value && s2_x_q >= s2_q.end_value);

  `ASSERT_AT(a_ramp_range, s2_v_q && s2_ramp && !s2_err |-> ramp_in_range,
    "ramp value outside segment endpoints")
  `ASSERT_AT(a_skid_fill, in_valid_i && !skid_v_q && !adv |=> skid_v_q,
    "beat taken during stall was not parked in skid")
  `ASSERT_NEVER(a_skid_move, skid_v_q && !$past(!adv),
    "skid holds a beat although the pipeline advanced")

endmodule

// File: src/inct_scale.sv
// Pipelined (a*b)/d on magnitudes: split multiply, overflow check, then one
// restoring quotient bit per stage. A zero divisor yields a zero quotient.
module inct_scale #(
  parameter int unsigned A_W    = 40,
  parameter int unsigned B_W    = 33,
  parameter int unsigned D_W    = 40,
  parameter int unsigned Q_W    = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [A_W-1:0]             a_i,
  input  logic [B_W-1:0]             b_i,
  input  logic [D_W-1:0]             d_i,
  input  logic                       neg_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [Q_W-1:0]             quo_o,
  output inct_pkg::scale_flags_t     flags_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned AP_W = (A_W > 33) ? A_W : 33;
  localparam int unsigned AH_W = AP_W - 32;
  localparam int unsigned P_W  = AP_W + B_W;
  localparam int unsigned HI_W = P_W - Q_W;
  localparam int unsigned CW   = (HI_W > D_W) ? HI_W : D_W;

  logic [AP_W-1:0] a_ext;
  assign a_ext = AP_W'(a_i);

  // Partial products
  logic                  m1_v_q;
  logic [32+B_W-1:0]     pl_q;
  logic [AH_W+B_W-1:0]   ph_q;
  logic [D_W-1:0]        m1_d_q;
  logic                  m1_neg_q;
  logic [SIDE_W-1:0]     m1_side_q;

  // Full product
  logic                  m2_v_q;
  logic [P_W-1:0]        m2_p_q;
  logic [D_W-1:0]        m2_d_q;
  logic                  m2_neg_q;
  logic [SIDE_W-1:0]     m2_side_q;

  logic [CW-1:0]         hi_ext;
  assign hi_ext = CW'(m2_p_q[P_W-1:Q_W]);

  // Quotient stages, index 0 holds the start of the division
  logic                  st_v_q    [Q_W+1];
  logic [D_W-1:0]        rem_q     [Q_W+1];
  logic [Q_W-1:0]        num_q     [Q_W+1];
  logic [Q_W-1:0]        quo_q     [Q_W+1];
  logic [D_W-1:0]        dv_q      [Q_W+1];
  logic                  neg_q     [Q_W+1];
  logic                  ovf_q     [Q_W+1];
  logic                  zero_q    [Q_W+1];
  logic [SIDE_W-1:0]     side_q    [Q_W+1];

  logic [D_W:0]          r2_w      [Q_W];
  logic [D_W:0]          diff_w    [Q_W];
  logic                  ge_w      [Q_W];
  logic [D_W-1:0]        rem_d     [Q_W];
  logic [Q_W-1:0]        quo_d     [Q_W];

  // One trial subtract per stage
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      r2_w[k]   = {rem_q[k], num_q[k][Q_W-1]};
      diff_w[k] = r2_w[k] - {1'b0, dv_q[k]};
      ge_w[k]   = (r2_w[k] >= {1'b0, dv_q[k]});
      rem_d[k]  = ge_w[k] ? diff_w[k][D_W-1:0] : r2_w[k][D_W-1:0];
      quo_d[k]  = {quo_q[k][Q_W-2:0], ge_w[k]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      for (int k = 0; k <= Q_W; k++) st_v_q[k] <= 1'b0;
    end else if (en_i) begin
      m1_v_q    <= valid_i;
      m2_v_q    <= m1_v_q;
      st_v_q[0] <= m2_v_q;
      for (int k = 0; k < Q_W; k++) st_v_q[k+1] <= st_v_q[k];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q      <= (32+B_W)'(a_ext[31:0]) * (32+B_W)'(b_i);
      ph_q      <= (AH_W+B_W)'(a_ext[AP_W-1:32]) * (AH_W+B_W)'(b_i);
      m1_d_q    <= d_i;
      m1_neg_q  <= neg_i;
      m1_side_q <= side_i;

      m2_p_q    <= P_W'(pl_q) + (P_W'(ph_q) << 32);
      m2_d_q    <= m1_d_q;
      m2_neg_q  <= m1_neg_q;
      m2_side_q <= m1_side_q;

      rem_q[0]  <= hi_ext[D_W-1:0];
      num_q[0]  <= m2_p_q[Q_W-1:0];
      quo_q[0]  <= '0;
      dv_q[0]   <= m2_d_q;
      neg_q[0]  <= m2_neg_q;
      ovf_q[0]  <= (hi_ext >= CW'(m2_d_q));
      zero_q[0] <= (m2_d_q == '0);
      side_q[0] <= m2_side_q;

      for (int k = 0; k < Q_W; k++) begin
        rem_q[k+1]  <= rem_d[k];
        num_q[k+1]  <= {num_q[k][Q_W-2:0], 1'b0};
        quo_q[k+1]  <= quo_d[k];
        dv_q[k+1]   <= dv_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        zero_q[k+1] <= zero_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o     = st_v_q[Q_W];
  assign quo_o       = zero_q[Q_W] ? '0 : quo_q[Q_W];
  assign flags_o.ovf = ovf_q[Q_W] & ~zero_q[Q_W];
  assign flags_o.neg = neg_q[Q_W] & ~zero_q[Q_W];
  assign side_o      = side_q[Q_W];

endmodule

// File: tb/interp_next_change_time_checker.sv
module interp_next_change_time_checker
  import inct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_item_t  out_data_i,
  output int         fail_count_o,
  output int         pending_count_o
);

  localparam logic signed [131:0] NEXT_MAX = (132'sd1 <<< NEXT_W) - 1;
  localparam logic signed [131:0] VAL_MAX  = 132'sd2147483647;
  localparam logic signed [131:0] VAL_MIN  = -132'sd2147483648;

  out_item_t expected_q[$];
  int        fail_count;

  function automatic logic signed [131:0] mag(input logic signed [131:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Truncated (a*b)/d over signed operands; zero divisor yields zero.
  function automatic logic signed [131:0] scaled(input logic signed [131:0] a,
                                                 input logic signed [131:0] b,
                                                 input logic signed [131:0] d);
    logic [131:0] q;
    if (d == 0) return 0;
    q = ($unsigned(mag(a)) * $unsigned(mag(b))) / $unsigned(mag(d));
    return (((a < 0) ^ (b < 0) ^ (d < 0))) ? -$signed(q) : $signed(q);
  endfunction

  // Compute value at now and next change time of one segment.
  function automatic out_item_t interp_segment(input in_item_t it);
    logic signed [131:0] t1, tn, t2, x1, x2, x, nx, tgt;
    out_item_t r;
    t1 = $signed({92'd0, it.seg_start_time});
    tn = $signed({92'd0, it.now_time});
    t2 = $signed({92'd0, it.seg_end_time});
    x1 = it.start_value;
    x2 = it.end_value;
    if (tn == t2) begin
      x  = x2;
      nx = t2 + 1;
    end else if (it.hold_mode) begin
      x  = x1;
      nx = (t2 == 0) ? 0 : t2 - 1;
      if (nx == tn) nx = t2;
    end else if (x1 == x2) begin
      x  = x2;
      nx = t2;
    end else begin
      x = x1 + scaled(tn - t1, x2 - x1, t2 - t1);
      if (x > VAL_MAX) x = VAL_MAX;
      if (x < VAL_MIN) x = VAL_MIN;
      tgt = x + ((x2 < x1) ? -1 : 1);
      nx = t1 + scaled(tgt - x1, t2 - t1, x2 - x1);
      if (nx > NEXT_MAX) nx = NEXT_MAX;
      if (nx < 0) nx = 0;
      if (nx <= tn) nx = tn + 1;
    end
    if (nx == tn) nx = t2;
    r.current_value = x[VAL_W-1:0];
    r.next_time     = nx[NEXT_W-1:0];
    r.order_error   = !(t1 <= tn && tn <= t2);
    return r;
  endfunction

  // Predict on each input beat, compare on each output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(interp_segment(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %h", $time, out_data_i);
        end else begin
          want = expected_q.pop_front();
          if (want.current_value !== out_data_i.current_value) begin
            fail_count++;
            $display("%0t: current_value expected %0d actual %0d", $time,
                     want.current_value, out_data_i.current_value);
          end
          if (want.next_time !== out_data_i.next_time) begin
            fail_count++;
            $display("%0t: next_time expected %0d actual %0d", $time,
                     want.next_time, out_data_i.next_time);
          end
          if (want.order_error !== out_data_i.order_error) begin
            fail_count++;
            $display("%0t: order_error expected %0b actual %0b", $time,
                     want.order_error, out_data_i.order_error);
          end
        end
      end
    end
  end

  assign fail_count_o    = fail_count;
  assign pending_count_o = expected_q.size();

endmodule

// File: tb/testbench.sv
module testbench;
  import inct_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      in_took;
  int        fail_count;
  int        pending_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  interp_next_change_time_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  interp_next_change_time_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Record whether the last edge moved an input beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
    end
  end

  // Stall the output at random.
  always @(negedge clk_i) begin
    out_stall = ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(40))) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Present one beat and hold it until taken.
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(negedge clk_i); while (!in_took);
    in_valid = 1'b0;
  endtask

  task automatic send_seg(input logic [TIME_BITS-1:0] t1, input logic [TIME_BITS-1:0] tn,
                          input logic [TIME_BITS-1:0] t2, input int x1, input int x2,
                          input logic hold);
    in_item_t it;
    it.seg_start_time = t1;
    it.now_time       = tn;
    it.seg_end_time   = t2;
    it.start_value    = x1;
    it.end_value      = x2;
    it.hold_mode      = hold;
    send_beat(it);
  endtask

  // Mostly ordered segments, some close together, some noise.
  task automatic send_random();
    in_item_t it;
    logic [TIME_BITS-1:0] a, b, c, s;
    a = rand_time();
    b = rand_time();
    c = rand_time();
    if ($urandom_range(2) == 0) begin
      b = a + $urandom_range(30);
      c = b + $urandom_range(30);
    end else if ($urandom_range(3) == 0) begin
      b = a + $urandom_range(2000);
      c = b + $urandom_range(2000);
    end
    if ($urandom_range(9) != 0) begin
      if (a > b) begin s = a; a = b; b = s; end
      if (b > c) begin s = b; b = c; c = s; end
      if (a > b) begin s = a; a = b; b = s; end
    end
    if ($urandom_range(9) == 0) b = c;
    it.seg_start_time = a;
    it.now_time       = b;
    it.seg_end_time   = c;
    it.start_value    = rand_value();
    it.end_value      = ($urandom_range(9) == 0) ? it.start_value : rand_value();
    it.hold_mode      = ($urandom_range(3) == 0);
    send_beat(it);
  endtask

  initial begin
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 87;
    rst_ni        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: ends, hold, flat, ramps, zero length, saturation, misordering.
    send_seg(0, 0, 0, 0, 0, 0);
    send_seg(TIME_MAX, TIME_MAX, TIME_MAX, -2147483648, 2147483647, 0);
    send_seg(0, 5, 0, 7, 9, 1);
    send_seg(10, 20, 21, 3, 9, 1);
    send_seg(10, 15, 30, 3, 9, 1);
    send_seg(10, 15, 30, 4, 4, 0);
    send_seg(0, 1, 10, 0, 100, 0);
    send_seg(0, 3, 10, 100, 0, 0);
    send_seg(0, 1, 1000, 0, 3, 0);
    send_seg(0, 999, 1000, 3, 0, 0);
    send_seg(0, TIME_MAX - 1, TIME_MAX, -2147483648, 2147483647, 0);
    send_seg(0, 1, TIME_MAX, 2147483647, -2147483648, 0);
    send_seg(50, 60, 50, 1, 2, 0);
    send_seg(50, 40, 50, 1, 2, 0);
    send_seg(10, 100, 20, 0, 2147483647, 0);
    send_seg(10, 100, 20, 0, -2147483648, 0);
    send_seg(TIME_MAX - 2, TIME_MAX - 1, TIME_MAX, 0, 1, 0);
    send_seg(5, 0, TIME_MAX, 2147483647, 2147483646, 0);
    send_seg(TIME_MAX, 0, 0, 1, 5, 0);
    send_seg(0, TIME_MAX, 0, -5, 5, 1);

    repeat (510) send_random();
    send_idle_pct = 87;
    recv_idle_pct = 27;
    repeat (510) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (510) send_random();

    while (pending_count != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: interp_next_change_time_unit.f
+incdir+src
src/inct_pkg.sv
src/inct_scale.sv
src/interp_next_change_time_unit.sv
tb/interp_next_change_time_checker.sv
tb/testbench.sv
